FILE: rtl/assert_macros.svh
// assertion macros for the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FFBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffba same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define FFBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffba next-cycle check failed");

`endif

FILE: rtl/ffba_pkg.sv
// types and constants of the first-fit block allocator
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W     = 32;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_RESIZE = 2'd2;
    localparam logic [1:0] OP_ARRAY  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NULL      = 3'd1;
    localparam logic [2:0] ST_NOROOM    = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_BADHANDLE = 3'd4;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              free;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } tbl_req_t;

endpackage

`default_nettype wire

FILE: rtl/ffba_table.sv
// block table memory: one write port, one registered read port
`default_nettype none

module ffba_table
    import ffba_pkg::*;
(
    input  wire logic     clk,
    input  wire tbl_req_t req,
    output entry_t        rdata
);

    entry_t mem [MAX_BLOCKS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/ffba_fit.sv
// shared size compare unit: entry size against the needed size
`default_nettype none

module ffba_fit
    import ffba_pkg::*;
(
    input  wire entry_t            entry,
    input  wire logic [SIZE_W-1:0] need,
    output logic                   big_enough,
    output logic                   fit
);

    assign big_enough = (entry.size >= need);
    // a candidate must be free and large enough
    assign fit        = entry.free & big_enough;

endmodule

`default_nettype wire

FILE: rtl/first_fit_block_allocator_top.sv
// first-fit block allocator: sequencer, table and shared compare unit
// a null, zero-size or bad-handle command is answered straight from idle; free
//   reads the entry and releases it; resize reads its entry and keeps it or rescans
//   for a new one and releases the old one; allocate walks the table, one table read
//   per cycle with a compare behind it; array allocate multiplies and checks first
// the block works on one command at a time
// the result beat shows for one cycle under done and cannot be stalled
// reset clears the sequencer, the result strobe and the block count; entries stay
`default_nettype none

`include "assert_macros.svh"

module first_fit_block_allocator_top
    import ffba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        op,
    input  wire logic [SIZE_W-1:0] request_size,
    input  wire logic [SIZE_W-1:0] element_size,
    input  wire logic [IDX_W-1:0]  handle,
    input  wire logic              handle_present,
    output logic                   done,
    output logic [IDX_W-1:0]       result_handle,
    output logic [2:0]             status,
    output logic                   reused
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1; // element count times element size
    localparam logic [2:0] S_MCHK  = 3'd2; // overflow check on the product
    localparam logic [2:0] S_HREAD = 3'd3; // read the entry named by the handle
    localparam logic [2:0] S_HDATA = 3'd4; // entry data back: release, keep or rescan
    localparam logic [2:0] S_SCAN  = 3'd5; // first-fit walk over the table
    localparam logic [2:0] S_REL   = 3'd6; // release the old entry

    logic [2:0]          state_reg,     state_next;
    logic [1:0]          op_reg,        op_next;
    logic [IDX_W-1:0]    h_reg,         h_next;
    logic [SIZE_W-1:0]   need_reg,      need_next;
    logic [SIZE_W-1:0]   esz_reg,       esz_next;
    logic [2*SIZE_W-1:0] prod_reg,      prod_next;
    logic [SIZE_W-1:0]   hsize_reg,     hsize_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [CNT_W-1:0]    rd_idx_reg,    rd_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]    chk_idx_reg,   chk_idx_next;
    logic [IDX_W-1:0]    gidx_reg,      gidx_next;
    logic                greuse_reg,    greuse_next;
    logic                done_reg,      done_next;
    logic [IDX_W-1:0]    handle_reg,    handle_out_next;
    logic [2:0]          status_reg,    status_next;
    logic                reused_reg,    reused_next;

    tbl_req_t tbl_req;
    entry_t   tbl_rdata;
    logic     big_enough;
    logic     fit;
    logic     issue;
    logic     hit;
    logic     last_entry;

    ffba_table u_table (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    // one compare unit serves both the handle check and the scan
    ffba_fit u_fit (
        .entry      (tbl_rdata),
        .need       (need_reg),
        .big_enough (big_enough),
        .fit        (fit)
    );

    // scan pipeline: address goes out one cycle, data is compared the next
    assign issue      = (rd_idx_reg < count_reg);
    assign hit        = chk_valid_reg & fit;
    assign last_entry = ((CNT_W'(h_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        h_next          = h_reg;
        need_next       = need_reg;
        esz_next        = esz_reg;
        prod_next       = prod_reg;
        hsize_next      = hsize_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        gidx_next       = gidx_reg;
        greuse_next     = greuse_reg;
        done_next       = 1'b0;
        handle_out_next = handle_reg;
        status_next     = status_reg;
        reused_next     = reused_reg;

        tbl_req.we    = 1'b0;
        tbl_req.waddr = h_reg;
        tbl_req.wdata = '{size: hsize_reg, free: 1'b1};
        tbl_req.raddr = (state_reg == S_SCAN) ? rd_idx_reg[IDX_W-1:0] : h_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = op;
                    h_next          = handle;
                    need_next       = request_size;
                    esz_next        = element_size;
                    rd_idx_next     = '0;
                    handle_out_next = '0;
                    reused_next     = 1'b0;
                    case (op)
                        OP_ALLOC:
                        begin
                            if (request_size == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NULL;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            if (!handle_present)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NULL;
                            end
                            else if (CNT_W'(handle) >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BADHANDLE;
                            end
                            else
                            begin
                                state_next = S_HREAD;
                            end
                        end
                        OP_RESIZE:
                        begin
                            // a null handle or a zero size acts as a plain allocate
                            if (request_size == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NULL;
                            end
                            else if (!handle_present)
                            begin
                                op_next    = OP_ALLOC;
                                state_next = S_SCAN;
                            end
                            else if (CNT_W'(handle) >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BADHANDLE;
                            end
                            else
                            begin
                                state_next = S_HREAD;
                            end
                        end
                        default:
                        begin
                            if (request_size == '0 || element_size == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NULL;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                    endcase
                end
            end

            S_MUL:
            begin
                prod_next  = {{SIZE_W{1'b0}}, need_reg} * {{SIZE_W{1'b0}}, esz_reg};
                state_next = S_MCHK;
            end

            S_MCHK:
            begin
                if (prod_reg[2*SIZE_W-1:SIZE_W] != '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OVERFLOW;
                    state_next  = S_IDLE;
                end
                else
                begin
                    need_next  = prod_reg[SIZE_W-1:0];
                    state_next = S_SCAN;
                end
            end

            S_HREAD:
            begin
                state_next = S_HDATA;
            end

            S_HDATA:
            begin
                hsize_next = tbl_rdata.size;
                if (op_reg == OP_FREE)
                begin
                    state_next = S_REL;
                end
                else if (big_enough)
                begin
                    // block already large enough, keep it
                    done_next       = 1'b1;
                    status_next     = ST_OK;
                    handle_out_next = h_reg;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                chk_valid_next = issue;
                chk_idx_next   = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    // reuse the first free entry that fits, size unchanged
                    chk_valid_next = 1'b0;
                    tbl_req.we     = 1'b1;
                    tbl_req.waddr  = chk_idx_reg;
                    tbl_req.wdata  = '{size: tbl_rdata.size, free: 1'b0};
                    gidx_next      = chk_idx_reg;
                    greuse_next    = 1'b1;
                    if (op_reg == OP_RESIZE)
                    begin
                        state_next = S_REL;
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        status_next     = ST_OK;
                        handle_out_next = chk_idx_reg;
                        reused_next     = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (!issue)
                begin
                    chk_valid_next = 1'b0;
                    if (count_reg == CNT_W'(MAX_BLOCKS))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NOROOM;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        // append a new entry at the end of the table
                        tbl_req.we    = 1'b1;
                        tbl_req.waddr = count_reg[IDX_W-1:0];
                        tbl_req.wdata = '{size: need_reg, free: 1'b0};
                        count_next    = count_reg + CNT_W'(1);
                        gidx_next     = count_reg[IDX_W-1:0];
                        greuse_next   = 1'b0;
                        if (op_reg == OP_RESIZE)
                        begin
                            state_next = S_REL;
                        end
                        else
                        begin
                            done_next       = 1'b1;
                            status_next     = ST_OK;
                            handle_out_next = count_reg[IDX_W-1:0];
                            state_next      = S_IDLE;
                        end
                    end
                end
            end

            S_REL:
            begin
                // pop the last entry, otherwise mark it free
                if (last_entry)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    tbl_req.we = 1'b1;
                end
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
                if (op_reg == OP_RESIZE)
                begin
                    handle_out_next = gidx_reg;
                    reused_next     = greuse_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        h_reg       <= h_next;
        need_reg    <= need_next;
        esz_reg     <= esz_next;
        prod_reg    <= prod_next;
        hsize_reg   <= hsize_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        gidx_reg    <= gidx_next;
        greuse_reg  <= greuse_next;
        handle_reg  <= handle_out_next;
        status_reg  <= status_next;
        reused_reg  <= reused_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign result_handle = handle_reg;
    assign status        = status_reg;
    assign reused        = reused_reg;

    // result beat only ever appears once the sequencer is back in idle
    `FFBA_ASSERT_NOW(a_done_idle, done, !busy)
    // an accepted command either answers at once or keeps the block busy
    `FFBA_ASSERT_NEXT(a_start_moves, start && !busy, busy || done)
    // the table never holds more entries than it has room for
    `FFBA_ASSERT_NOW(a_count_max, 1'b1, count_reg <= CNT_W'(MAX_BLOCKS))
    // a reused grant points at an entry that is still in the table
    `FFBA_ASSERT_NOW(a_reuse_inside, done && reused, CNT_W'(result_handle) < count_reg)

endmodule

`default_nettype wire

FILE: bench/alloc_checker.sv
// checker for the first-fit block allocator: predicts every answer and compares
`timescale 1ns / 1ps

module alloc_checker
    import ffba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [1:0]        op,
    input  wire logic [SIZE_W-1:0] request_size,
    input  wire logic [SIZE_W-1:0] element_size,
    input  wire logic [IDX_W-1:0]  handle,
    input  wire logic              handle_present,
    input  wire logic              done,
    input  wire logic [IDX_W-1:0]  result_handle,
    input  wire logic [2:0]        status,
    input  wire logic              reused,
    output int                     fail_count,
    output int                     outstanding,
    output logic [CNT_W-1:0]       table_count
);

    typedef struct packed {
        logic [IDX_W-1:0] slot;
        logic [2:0]       code;
        logic             reuse;
    } answer_t;

    logic [SIZE_W-1:0] shadow_size [MAX_BLOCKS];
    logic              shadow_free [MAX_BLOCKS];
    answer_t           expected_answers [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
        table_count = '0;
    end

    task automatic note_failure(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        fail_count++;
    endtask

    // first fit over the live entries, append when nothing fits
    function automatic logic [2:0] take_block(input logic [63:0] bytes,
                                              output logic [IDX_W-1:0] slot,
                                              output logic again);
        slot  = '0;
        again = 1'b0;
        if (bytes == 64'd0)
            return ST_NULL;
        if (bytes > 64'hFFFF_FFFF)
            return ST_OVERFLOW;
        for (int i = 0; i < int'(table_count); i++)
        begin
            if (shadow_free[i] && shadow_size[i] >= bytes[SIZE_W-1:0])
            begin
                shadow_free[i] = 1'b0;
                slot           = IDX_W'(i);
                again          = 1'b1;
                return ST_OK;
            end
        end
        if (int'(table_count) >= MAX_BLOCKS)
            return ST_NOROOM;
        shadow_size[table_count[IDX_W-1:0]] = bytes[SIZE_W-1:0];
        shadow_free[table_count[IDX_W-1:0]] = 1'b0;
        slot        = table_count[IDX_W-1:0];
        table_count = table_count + 1'b1;
        return ST_OK;
    endfunction

    // the last entry pops, any other one is only marked free
    function automatic void drop_block(input logic [IDX_W-1:0] h);
        if (CNT_W'(h) + 1'b1 == table_count)
            table_count = table_count - 1'b1;
        else
            shadow_free[h] = 1'b1;
    endfunction

    function automatic answer_t predict_answer(input logic [1:0]        c_op,
                                               input logic [SIZE_W-1:0] req,
                                               input logic [SIZE_W-1:0] esz,
                                               input logic [IDX_W-1:0]  h,
                                               input logic              hp);
        answer_t          a;
        logic [2:0]       code;
        logic [IDX_W-1:0] slot;
        logic             again;
        code  = ST_OK;
        slot  = '0;
        again = 1'b0;
        case (c_op)
            OP_ALLOC:
                code = take_block(64'(req), slot, again);
            OP_FREE:
                if (!hp)
                    code = ST_NULL;
                else if (CNT_W'(h) >= table_count)
                    code = ST_BADHANDLE;
                else
                    drop_block(h);
            OP_RESIZE:
                if (!hp || req == '0)
                    code = take_block(64'(req), slot, again);
                else if (CNT_W'(h) >= table_count)
                    code = ST_BADHANDLE;
                else if (shadow_size[h] >= req)
                    slot = h;
                else
                begin
                    code = take_block(64'(req), slot, again);
                    if (code == ST_OK)
                        drop_block(h);
                end
            default:
                if (req == '0 || esz == '0)
                    code = ST_NULL;
                else
                    code = take_block(64'(req) * 64'(esz), slot, again);
        endcase
        if (code != ST_OK)
        begin
            slot  = '0;
            again = 1'b0;
        end
        a.slot  = slot;
        a.code  = code;
        a.reuse = again;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            table_count = '0;
            expected_answers.delete();
        end
        else
        begin
            if (start && !busy)
                expected_answers.push_back(predict_answer(op, request_size, element_size,
                                                          handle, handle_present));
            if (done)
            begin
                if (expected_answers.size() == 0)
                    note_failure($sformatf("answer with none expected: handle %0d status %0d",
                                           result_handle, status));
                else
                begin
                    want = expected_answers.pop_front();
                    if (result_handle !== want.slot)
                        note_failure($sformatf("result_handle got %0d want %0d",
                                               result_handle, want.slot));
                    if (status !== want.code)
                        note_failure($sformatf("status got %0d want %0d", status, want.code));
                    if (reused !== want.reuse)
                        note_failure($sformatf("reused got %0d want %0d", reused, want.reuse));
                end
            end
        end
        outstanding = expected_answers.size();
    end

endmodule

FILE: bench/testbench.sv
// stimulus and verdict for the first-fit block allocator
`timescale 1ns / 1ps

module testbench;
    import ffba_pkg::*;

    // cycles with no beat in either direction before the run is called hung;
    // the longest command and the sender gaps stay far below this
    localparam int QUIET_LIMIT = 4000;
    // settle time at the end of the run, in clock cycles
    localparam int DRAIN_CYCLES = 80;
    localparam int SEGMENT_ITEMS = 40;
    localparam int SEGMENTS = 26;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [1:0]        op = OP_ALLOC;
    logic [SIZE_W-1:0] request_size = '0;
    logic [SIZE_W-1:0] element_size = '0;
    logic [IDX_W-1:0]  handle = '0;
    logic              handle_present = 1'b0;
    wire logic              busy;
    wire logic              done;
    wire logic [IDX_W-1:0]  result_handle;
    wire logic [2:0]        status;
    wire logic              reused;

    int               fail_count;
    int               outstanding;
    logic [CNT_W-1:0] table_count;

    // chance in percent that the sender waits before the next command, drawn anew after each wait
    int idle_pct = 0;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    first_fit_block_allocator_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .request_size   (request_size),
        .element_size   (element_size),
        .handle         (handle),
        .handle_present (handle_present),
        .done           (done),
        .result_handle  (result_handle),
        .status         (status),
        .reused         (reused)
    );

    // watches both channels, keeps its own copy of the table and compares
    alloc_checker alloc_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .request_size   (request_size),
        .element_size   (element_size),
        .handle         (handle),
        .handle_present (handle_present),
        .done           (done),
        .result_handle  (result_handle),
        .status         (status),
        .reused         (reused),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .table_count    (table_count)
    );

    // hang detection: any command beat or answer beat restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one command beat; inputs move at the falling edge, busy is looked at on the
    // rising edge, and start stays high until the block takes the beat
    task automatic send_command(input logic [1:0]        c_op,
                                input logic [SIZE_W-1:0] req,
                                input logic [SIZE_W-1:0] esz,
                                input logic [IDX_W-1:0]  h,
                                input logic              hp);
        @(negedge clk);
        // random gaps, which also land while the block is still working
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        op             <= c_op;
        request_size   <= req;
        element_size   <= esz;
        handle         <= h;
        handle_present <= hp;
        start          <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // mostly small sizes so freed entries get reused, now and then huge ones
    function automatic logic [SIZE_W-1:0] pick_bytes();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 70)
            return SIZE_W'($urandom_range(1, 64));
        if (r < 88)
            return SIZE_W'($urandom_range(65, 4096));
        return SIZE_W'($urandom);
    endfunction

    // mostly live handles, with a bias toward the last entry so pops happen
    function automatic logic [IDX_W-1:0] pick_handle(input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < 10 || table_count == '0)
            return IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
        if (r < 10 + pop_pct)
            return IDX_W'(table_count - 1'b1);
        return IDX_W'($urandom_range(0, int'(table_count) - 1));
    endfunction

    // mode 0 fills the table, 1 is an even mix, 2 drains it from the top
    task automatic random_command(input int mode);
        int                r;
        int                n;
        int                alloc_pct;
        int                free_pct;
        int                resize_pct;
        int                pop_pct;
        logic [1:0]        c_op;
        logic [SIZE_W-1:0] req;
        logic [SIZE_W-1:0] esz;
        logic [IDX_W-1:0]  h;
        logic              hp;
        case (mode)
            0:
            begin
                alloc_pct = 55; free_pct = 15; resize_pct = 15; pop_pct = 20;
            end
            1:
            begin
                alloc_pct = 30; free_pct = 30; resize_pct = 25; pop_pct = 30;
            end
            default:
            begin
                alloc_pct = 10; free_pct = 65; resize_pct = 15; pop_pct = 70;
            end
        endcase
        r   = $urandom_range(99);
        req = pick_bytes();
        esz = SIZE_W'($urandom);
        h   = IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
        hp  = ($urandom_range(99) < 95);
        if (r < alloc_pct)
            c_op = OP_ALLOC;
        else if (r < alloc_pct + free_pct)
        begin
            c_op = OP_FREE;
            h    = pick_handle(pop_pct);
        end
        else if (r < alloc_pct + free_pct + resize_pct)
        begin
            c_op = OP_RESIZE;
            h    = pick_handle(pop_pct);
        end
        else
        begin
            c_op = OP_ARRAY;
            r    = $urandom_range(99);
            if (r < 40)
            begin
                req = SIZE_W'($urandom_range(1, 64));
                esz = SIZE_W'($urandom_range(1, 64));
            end
            else if (r < 55)
            begin
                // zero count or zero element size
                if ($urandom_range(1))
                    req = '0;
                else
                    esz = '0;
            end
            else if (r < 80)
            begin
                req = SIZE_W'($urandom);
            end
            else
            begin
                // product just under or just over the 32-bit limit
                n   = $urandom_range(1, 8);
                req = SIZE_W'(n);
                esz = SIZE_W'(32'hFFFF_FFFF / n) + SIZE_W'($urandom_range(0, 1));
            end
        end
        send_command(c_op, req, esz, h, hp);
    endtask

    initial
    begin
        // reset held low from the start, released on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every op, both size extremes and each corner case
        idle_pct = 0;
        send_command(OP_ALLOC, '0, '0, '0, 1'b0);               // zero size
        send_command(OP_ALLOC, 32'd100, '0, '0, 1'b0);          // append entry 0
        send_command(OP_ALLOC, 32'hFFFF_FFFF, '1, '1, 1'b1);    // largest byte size
        send_command(OP_ALLOC, 32'd50, '0, '0, 1'b0);           // append entry 2
        send_command(OP_FREE, '0, '0, 6'd0, 1'b1);              // non-last free marks it
        send_command(OP_FREE, '0, '0, 6'd0, 1'b1);              // double free
        send_command(OP_ALLOC, 32'd80, '0, '0, 1'b0);           // first fit reuses entry 0
        send_command(OP_FREE, '0, '0, 6'd1, 1'b0);              // null free
        send_command(OP_FREE, '0, '0, 6'd63, 1'b1);             // handle past the count
        send_command(OP_RESIZE, 32'd40, '0, 6'd2, 1'b1);        // already fits, kept
        send_command(OP_RESIZE, '0, '0, 6'd2, 1'b1);            // zero size leaves it
        send_command(OP_RESIZE, 32'd10, '0, 6'd5, 1'b0);        // null resize allocates
        send_command(OP_RESIZE, 32'd1000, '0, 6'd3, 1'b1);      // grows, old one freed
        send_command(OP_RESIZE, 32'd5, '0, 6'd40, 1'b1);        // resize bad handle
        send_command(OP_FREE, '0, '0, 6'd4, 1'b1);              // last entry pops
        send_command(OP_FREE, '0, '0, 6'd3, 1'b1);              // free one now last
        send_command(OP_ARRAY, '0, 32'd8, '0, 1'b0);            // zero count
        send_command(OP_ARRAY, 32'd8, '0, '0, 1'b0);            // zero element size
        send_command(OP_ARRAY, 32'h0001_0000, 32'h0001_0000, '0, 1'b0); // exactly 2^32
        send_command(OP_ARRAY, 32'h0000_FFFF, 32'h0001_0001, '0, 1'b0); // 2^32 - 1 fits
        send_command(OP_ARRAY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0); // widest product
        send_command(OP_ARRAY, 32'd3, 32'd7, 6'h2A, 1'b1);      // small array
        send_command(OP_RESIZE, 32'hFFFF_FFFF, '0, 6'd0, 1'b1); // grow to largest size

        // random: segments rotate through fill, mix and drain, and the sender
        // idle rate steps through none, heavy and light on a slower rotation
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case ((seg / 3) % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 85;
                default: idle_pct = 35;
            endcase
            for (int k = 0; k < SEGMENT_ITEMS; k++)
                random_command(seg % 3);
        end

        // drop start, wait for the last answer, then let the block settle
        @(negedge clk);
        start <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
